### hdl/pmst_pkg.sv
// Package for the dense Prim spanning tree block: sequencer states, fixed port widths
// and the control struct for the shared select unit. No dependencies.
package pmst_pkg;

  localparam int unsigned CfgBits    = 4;
  localparam int unsigned VertexBits = 3;
  localparam int unsigned WeightBits = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_PICK,
    ST_RELAX,
    ST_OPAR,
    ST_OADJ,
    ST_OLOAD
  } state_e;

  typedef struct packed {
    logic clr;
    logic en;
    logic relax;
  } sel_ctrl_t;

endpackage

### hdl/pmst_in_if.sv
// Input channel of the spanning tree block: one adjacency matrix entry per transaction.
// Depends on pmst_pkg for the field widths.
interface pmst_in_if import pmst_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [VertexBits-1:0] row;
  logic [VertexBits-1:0] col;
  logic [WeightBits-1:0] weight;
  logic                  last_entry;

  modport source (output valid, row, col, weight, last_entry, input ready);
  modport sink   (input valid, row, col, weight, last_entry, output ready);
endinterface

### hdl/pmst_out_if.sv
// Output channel of the spanning tree block: one tree edge per transaction.
// Depends on pmst_pkg for the field widths.
interface pmst_out_if import pmst_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [VertexBits-1:0] parent_vertex;
  logic [VertexBits-1:0] child_vertex;
  logic [WeightBits-1:0] edge_weight;
  logic                  unreachable;
  logic                  last_edge;

  modport source (output valid, parent_vertex, child_vertex, edge_weight, unreachable,
                  last_edge, input ready);
  modport sink   (input valid, parent_vertex, child_vertex, edge_weight, unreachable,
                  last_edge, output ready);
endinterface

### hdl/prim_mst_adjacency_matrix.sv
// Dense Prim minimum spanning tree over an adjacency matrix loaded entry by entry.
// Depends on pmst_pkg, pmst_in_if, pmst_out_if and pmst_sel_unit.
//
// Usage:
//   in_i carries one matrix entry (row, col, weight, last_entry) per transaction.
//   Entries are taken one per cycle while the block is idle; weight zero means no edge.
//   The entry flagged last_entry starts the tree build over the first n vertices,
//   n = active_vertices clamped to 2 .. MAX_VERTICES, written through cfg_we_i/cfg_wdata_i
//   while the block is idle (reset value 8).
//   out_o then delivers one edge per child vertex 1 .. n-1 in ascending order; an
//   unreachable child is flagged with parent and weight zero; last_edge marks child n-1.
// Sequence and throughput:
//   One setup step, then up to n-1 rounds of a pick scan and a relax scan over the n
//   vertices each, then the steps OPAR, OADJ and OLOAD per result edge. The build is
//   paced by the single shared compare unit visiting one vertex per cycle over one
//   read port per memory.
//   in_i is not ready during the build and result phase.
// Reset and stall:
//   Reset returns the sequencer to idle and drops any pending result; the matrix
//   memory is not cleared. When out_o stalls, the result register holds and the
//   sequencer waits; after the last edge is registered the block accepts entries again.
module prim_mst_adjacency_matrix import pmst_pkg::*; #(
  parameter int unsigned MAX_VERTICES = 8,
  parameter int unsigned WEIGHT_BITS  = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgBits-1:0] cfg_wdata_i,
  pmst_in_if.sink            in_i,
  pmst_out_if.source         out_o
);

  localparam int unsigned VW     = $clog2(MAX_VERTICES);
  localparam int unsigned NW     = $clog2(MAX_VERTICES + 1);
  localparam int unsigned KW     = WEIGHT_BITS + 1;
  localparam int unsigned AW     = 2 * VW;
  localparam int unsigned ADEPTH = 1 << AW;

  state_e state_q, state_d;

  logic [CfgBits-1:0]      cfg_q;
  logic [NW-1:0]           n_q, n_d;
  logic [NW-1:0]           round_q, round_d;
  logic [NW-1:0]           iss_q, iss_d;
  logic                    rd_vld_q, rd_vld_d;
  logic [VW-1:0]           rd_idx_q, rd_idx_d;
  logic [VW-1:0]           u_q, u_d;
  logic [MAX_VERTICES-1:0] in_tree_q, in_tree_d;
  logic [MAX_VERTICES-1:0] key_vld_q, key_vld_d;

  logic [WEIGHT_BITS-1:0] adj_mem [ADEPTH];
  logic [WEIGHT_BITS-1:0] adj_rdata_q;
  logic                   adj_we, adj_re;
  logic [AW-1:0]          adj_waddr, adj_raddr;

  logic [KW-1:0] key_mem [MAX_VERTICES];
  logic [KW-1:0] key_rdata_q, key_wdata;
  logic          key_we, key_re;
  logic [VW-1:0] key_waddr;

  logic [VW-1:0] par_mem [MAX_VERTICES];
  logic [VW-1:0] par_rdata_q;
  logic          par_we, par_re;

  logic                  out_vld_q, out_vld_d;
  logic [VertexBits-1:0] out_par_q, out_child_q;
  logic [WeightBits-1:0] out_w_q;
  logic                  out_unr_q, out_last_q;

  logic          in_acc, row_ok, col_ok;
  logic          scan_done, last_round, last_v, load, reached;
  logic [KW-1:0] key_eff;
  sel_ctrl_t     sel_ctrl;
  logic          found, upd;
  logic [VW-1:0] pick_idx;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign row_ok     = int'(in_i.row) < MAX_VERTICES;
  assign col_ok     = int'(in_i.col) < MAX_VERTICES;

  assign scan_done  = rd_vld_q && (NW'(rd_idx_q) == n_q - NW'(1));
  assign last_round = (round_q + NW'(1)) == (n_q - NW'(1));
  assign last_v     = iss_q == n_q - NW'(1);
  assign load       = (state_q == ST_OLOAD) && (!out_vld_q || out_o.ready);
  assign key_eff    = key_vld_q[rd_idx_q] ? key_rdata_q : '1;
  assign reached    = key_vld_q[iss_q[VW-1:0]];

  assign sel_ctrl.clr   = (state_q != ST_PICK);
  assign sel_ctrl.en    = rd_vld_q && ((state_q == ST_PICK) || (state_q == ST_RELAX));
  assign sel_ctrl.relax = (state_q == ST_RELAX);

  pmst_sel_unit #(
    .KW (KW),
    .VW (VW)
  ) u_sel (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (sel_ctrl),
    .idx_i      (rd_idx_q),
    .key_i      (key_eff),
    .weight_i   (adj_rdata_q),
    .in_tree_i  (in_tree_q[rd_idx_q]),
    .found_o    (found),
    .pick_idx_o (pick_idx),
    .upd_o      (upd)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && in_i.last_entry) state_d = ST_INIT;
      end
      ST_INIT: state_d = ST_PICK;
      ST_PICK: begin
        if (scan_done) state_d = found ? ST_RELAX : ST_OPAR;
      end
      ST_RELAX: begin
        if (scan_done) state_d = last_round ? ST_OPAR : ST_PICK;
      end
      ST_OPAR: state_d = ST_OADJ;
      ST_OADJ: state_d = ST_OLOAD;
      ST_OLOAD: begin
        if (load) state_d = last_v ? ST_IDLE : ST_OPAR;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    n_d       = n_q;
    round_d   = round_q;
    iss_d     = iss_q;
    rd_vld_d  = 1'b0;
    rd_idx_d  = rd_idx_q;
    u_d       = u_q;
    in_tree_d = in_tree_q;
    key_vld_d = key_vld_q;
    adj_we    = 1'b0;
    adj_waddr = {VW'(in_i.row), VW'(in_i.col)};
    adj_re    = 1'b0;
    adj_raddr = '0;
    key_we    = 1'b0;
    key_re    = 1'b0;
    key_waddr = rd_idx_q;
    key_wdata = KW'(adj_rdata_q);
    par_we    = 1'b0;
    par_re    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        adj_we = in_acc && row_ok && col_ok;
      end
      ST_INIT: begin
        if (int'(cfg_q) < 2) begin
          n_d = NW'(2);
        end else if (int'(cfg_q) > MAX_VERTICES) begin
          n_d = NW'(MAX_VERTICES);
        end else begin
          n_d = NW'(cfg_q);
        end
        round_d      = '0;
        iss_d        = '0;
        in_tree_d    = '0;
        key_vld_d    = '0;
        key_vld_d[0] = 1'b1;
        key_we       = 1'b1;
        key_waddr    = '0;
        key_wdata    = '0;
      end
      ST_PICK, ST_RELAX: begin
        if (iss_q < n_q) begin
          key_re   = 1'b1;
          rd_vld_d = 1'b1;
          rd_idx_d = iss_q[VW-1:0];
          iss_d    = iss_q + NW'(1);
          if (state_q == ST_RELAX) begin
            adj_re    = 1'b1;
            adj_raddr = {u_q, iss_q[VW-1:0]};
          end
        end
        if (state_q == ST_PICK) begin
          if (scan_done) begin
            if (found) begin
              iss_d               = '0;
              u_d                 = pick_idx;
              in_tree_d[pick_idx] = 1'b1;
            end else begin
              iss_d = NW'(1);
            end
          end
        end else begin
          if (upd) begin
            key_we              = 1'b1;
            par_we              = 1'b1;
            key_vld_d[rd_idx_q] = 1'b1;
          end
          if (scan_done) begin
            round_d = round_q + NW'(1);
            iss_d   = last_round ? NW'(1) : '0;
          end
        end
      end
      ST_OPAR: begin
        par_re = 1'b1;
      end
      ST_OADJ: begin
        adj_re    = 1'b1;
        adj_raddr = {iss_q[VW-1:0], par_rdata_q};
      end
      ST_OLOAD: begin
        if (load && !last_v) iss_d = iss_q + NW'(1);
      end
      default: begin
        iss_d = iss_q;
      end
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (load) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adj_we) adj_mem[adj_waddr] <= WEIGHT_BITS'(in_i.weight);
    if (adj_re) adj_rdata_q <= adj_mem[adj_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (key_we) key_mem[key_waddr] <= key_wdata;
    if (key_re) key_rdata_q <= key_mem[iss_q[VW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (par_we) par_mem[rd_idx_q] <= u_q;
    if (par_re) par_rdata_q <= par_mem[iss_q[VW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_par_q   <= reached ? VertexBits'(par_rdata_q) : '0;
      out_child_q <= VertexBits'(iss_q);
      out_w_q     <= reached ? WeightBits'(adj_rdata_q) : '0;
      out_unr_q   <= !reached;
      out_last_q  <= last_v;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cfg_q     <= CfgBits'(8);
      n_q       <= NW'(2);
      round_q   <= '0;
      iss_q     <= '0;
      rd_vld_q  <= 1'b0;
      rd_idx_q  <= '0;
      u_q       <= '0;
      in_tree_q <= '0;
      key_vld_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      if (cfg_we_i) cfg_q <= cfg_wdata_i;
      n_q       <= n_d;
      round_q   <= round_d;
      iss_q     <= iss_d;
      rd_vld_q  <= rd_vld_d;
      rd_idx_q  <= rd_idx_d;
      u_q       <= u_d;
      in_tree_q <= in_tree_d;
      key_vld_q <= key_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.parent_vertex = out_par_q;
  assign out_o.child_vertex  = out_child_q;
  assign out_o.edge_weight   = out_w_q;
  assign out_o.unreachable   = out_unr_q;
  assign out_o.last_edge     = out_last_q;

  a_tree_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RELAX) |-> ($countones(in_tree_q) == int'(round_q) + 1))
    else $error("tree size does not match round count");

  a_root_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_PICK) || (state_q == ST_RELAX)) |-> key_vld_q[0])
    else $error("root key lost during build");

  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (NW'(rd_idx_q) < n_q))
    else $error("scan index beyond vertex count");

  a_load_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == ST_OLOAD))
    else $error("result loaded outside load step");

endmodule

### hdl/pmst_sel_unit.sv
// Shared compare unit: tracks the minimum key during a pick scan and flags key updates
// during a relax scan. Depends on pmst_pkg for sel_ctrl_t.
module pmst_sel_unit import pmst_pkg::*; #(
  parameter int unsigned KW = 17,
  parameter int unsigned VW = 3
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sel_ctrl_t     ctrl_i,
  input  logic [VW-1:0] idx_i,
  input  logic [KW-1:0] key_i,
  input  logic [KW-2:0] weight_i,
  input  logic          in_tree_i,
  output logic          found_o,
  output logic [VW-1:0] pick_idx_o,
  output logic          upd_o
);

  logic [KW-1:0] best_q, best_d;
  logic [VW-1:0] idx_q, idx_d;
  logic          found_q, found_d;
  logic [KW-1:0] a_s, b_s;
  logic          lt, take;

  assign a_s  = ctrl_i.relax ? {1'b0, weight_i} : key_i;
  assign b_s  = ctrl_i.relax ? key_i : best_q;
  assign lt   = a_s < b_s;
  assign take = ctrl_i.en && !ctrl_i.relax && !in_tree_i && lt;

  assign upd_o = ctrl_i.en && ctrl_i.relax && (weight_i != '0) && !in_tree_i && lt;

  always_comb begin
    best_d  = take ? a_s : best_q;
    idx_d   = take ? idx_i : idx_q;
    found_d = take | found_q;
  end

  assign found_o    = found_d;
  assign pick_idx_o = idx_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q  <= '1;
      idx_q   <= '0;
      found_q <= 1'b0;
    end else if (ctrl_i.clr) begin
      best_q  <= '1;
      idx_q   <= '0;
      found_q <= 1'b0;
    end else begin
      best_q  <= best_d;
      idx_q   <= idx_d;
      found_q <= found_d;
    end
  end

endmodule
